// ===== src/dttfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttfp_pkg
// Shared types and constants for the decimal text to fixed-point parser.
// ----------------------------------------------------------------------------
package dttfp_pkg;

   localparam int NUM_W               = 48;
   localparam int MAG_W               = NUM_W - 1;
   localparam int MAX_FRAC_LIMIT      = 7;

   localparam int DEF_WHOLE_BITS      = 31;
   localparam int DEF_FRAC_BITS       = 16;
   localparam int DEF_MAX_FRAC_DIGITS = 5;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] number_out;
      logic                    text_valid;
      logic                    is_whole_number;
      logic                    is_above_zero;
      logic                    whole_saturated;
   } rsp_type;

   // finished text, handed from the parser to the output stage
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             minus;
      logic             valid;
      logic             frac_zero;
      logic             clamp;
   } fin_type;

endpackage
`default_nettype wire

// ===== src/dttfp_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttfp_parse
// Per-character parse state; on the last character it loads the finished
// magnitude and flags into a holding register and clears the parse state.
// ----------------------------------------------------------------------------
module dttfp_parse
   import dttfp_pkg::*;
#(
   parameter int WHOLE_BITS      = DEF_WHOLE_BITS,
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_valid,
   input  wire req_type item,
   output logic         item_take,
   input  wire logic    fin_take,
   output logic         fin_valid,
   output fin_type      fin
);

   localparam int WC     = (WHOLE_BITS < MAG_W - FRAC_BITS) ? WHOLE_BITS : MAG_W - FRAC_BITS;
   localparam int FD     = (MAX_FRAC_DIGITS > MAX_FRAC_LIMIT) ? MAX_FRAC_LIMIT
                                                              : MAX_FRAC_DIGITS;
   localparam longint DEN = longint'(10) ** FD;
   localparam int REM_W  = $clog2(DEN);
   localparam int CNT_W  = $clog2(FD + 1);
   localparam int IDX_W  = (FD > 1) ? $clog2(FD) : 1;

   // fraction kept as quotient and remainder of (digits * 2^F) / 10^FD,
   // digits padded to FD places; each digit adds a constant pair
   logic [FRAC_BITS-1:0] qt_tab [FD][10];
   logic [REM_W-1:0]     rt_tab [FD][10];

   for (genvar gk = 0; gk < FD; gk++) begin : g_pos
      for (genvar gd = 0; gd < 10; gd++) begin : g_dig
         localparam longint INC = longint'(gd) * (longint'(10) ** (FD - 1 - gk)) *
                                  (longint'(1) << FRAC_BITS);
         assign qt_tab[gk][gd] = FRAC_BITS'(INC / DEN);
         assign rt_tab[gk][gd] = REM_W'(INC % DEN);
      end
   end

   logic                 first_ff,  first_in;
   logic                 minus_ff,  minus_in;
   logic                 bad_ff,    bad_in;
   logic                 sep_ff,    sep_in;
   logic                 digit_ff,  digit_in;
   logic [WC-1:0]        whole_ff,  whole_in;
   logic [FRAC_BITS-1:0] quo_ff,    quo_in;
   logic [REM_W-1:0]     rem_ff,    rem_in;
   logic [CNT_W-1:0]     cnt_ff,    cnt_in;
   logic                 clamp_ff,  clamp_in;
   logic                 fin_valid_ff, fin_valid_in;
   fin_type              fin_ff,    fin_in;

   logic                 is_digit, is_sep, is_minus;
   logic [3:0]           digit;
   logic [WC+3:0]        whole_sum;
   logic [IDX_W-1:0]     pos;
   logic [REM_W:0]       rem_sum;
   logic                 wrap;

   assign item_take = item_valid &&
                      (!item.end_of_text || !fin_valid_ff || fin_take);

   always_comb begin
      is_digit  = item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
      is_sep    = item.char_code inside {CHAR_DOT, CHAR_COMMA};
      is_minus  = (item.char_code == CHAR_MINUS);
      digit     = 4'(item.char_code - CHAR_ZERO);
      whole_sum = {whole_ff, 3'b000} + {2'b00, whole_ff, 1'b0} + (WC + 4)'(digit);
      pos       = cnt_ff[IDX_W-1:0];
      rem_sum   = {1'b0, rem_ff} + {1'b0, rt_tab[pos][digit]};
      wrap      = (rem_sum >= (REM_W + 1)'(DEN));

      first_in  = 1'b0;
      minus_in  = minus_ff;
      bad_in    = bad_ff;
      sep_in    = sep_ff;
      digit_in  = digit_ff;
      whole_in  = whole_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      clamp_in  = clamp_ff;

      if (is_digit) begin
         digit_in = 1'b1;
         if (!sep_ff) begin
            // saturate the whole part at all ones
            if (whole_sum[WC+3:WC] != 4'b0000) begin
               whole_in = {WC{1'b1}};
               clamp_in = 1'b1;
            end else begin
               whole_in = whole_sum[WC-1:0];
            end
         end else if (cnt_ff < CNT_W'(FD)) begin
            quo_in = quo_ff + qt_tab[pos][digit] + FRAC_BITS'(wrap);
            rem_in = wrap ? REM_W'(rem_sum - (REM_W + 1)'(DEN)) : rem_sum[REM_W-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (is_sep) begin
         if (sep_ff) begin
            bad_in = 1'b1;
         end
         sep_in = 1'b1;
      end else if (is_minus) begin
         if (first_ff) begin
            minus_in = 1'b1;
         end else begin
            bad_in = 1'b1;
         end
      end else begin
         bad_in = 1'b1;
      end

      fin_in.mag       = MAG_W'({whole_in, quo_in});
      fin_in.minus     = minus_in;
      fin_in.valid     = !bad_in && digit_in;
      fin_in.frac_zero = (quo_in == '0);
      fin_in.clamp     = clamp_in;

      if (item_take && item.end_of_text) begin
         fin_valid_in = 1'b1;
      end else if (fin_take) begin
         fin_valid_in = 1'b0;
      end else begin
         fin_valid_in = fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         minus_ff     <= 1'b0;
         bad_ff       <= 1'b0;
         sep_ff       <= 1'b0;
         digit_ff     <= 1'b0;
         whole_ff     <= '0;
         quo_ff       <= '0;
         rem_ff       <= '0;
         cnt_ff       <= '0;
         clamp_ff     <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         if (item_take) begin
            if (item.end_of_text) begin
               // text done: back to the idle parse state
               first_ff <= 1'b1;
               minus_ff <= 1'b0;
               bad_ff   <= 1'b0;
               sep_ff   <= 1'b0;
               digit_ff <= 1'b0;
               whole_ff <= '0;
               quo_ff   <= '0;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               clamp_ff <= 1'b0;
            end else begin
               first_ff <= first_in;
               minus_ff <= minus_in;
               bad_ff   <= bad_in;
               sep_ff   <= sep_in;
               digit_ff <= digit_in;
               whole_ff <= whole_in;
               quo_ff   <= quo_in;
               rem_ff   <= rem_in;
               cnt_ff   <= cnt_in;
               clamp_ff <= clamp_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item.end_of_text) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule
`default_nettype wire

// ===== src/dttfp_format.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttfp_format
// Applies the sign, derives the result flags and holds the result beat
// until the receiver takes it.
// ----------------------------------------------------------------------------
module dttfp_format
   import dttfp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fin_valid,
   input  wire fin_type fin,
   output logic         fin_take,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       slot_free;
   logic [NUM_W-1:0] mag_ext;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fin_take  = fin_valid && slot_free;

   always_comb begin
      mag_ext = {1'b0, fin.mag};
      rsp_in  = '0;
      if (fin.valid) begin
         rsp_in.number_out      = fin.minus ? $signed(-mag_ext) : $signed(mag_ext);
         rsp_in.text_valid      = 1'b1;
         rsp_in.is_whole_number = fin.frac_zero;
         rsp_in.is_above_zero   = (fin.mag != '0) && !fin.minus;
         rsp_in.whole_saturated = fin.clamp;
      end
      rsp_valid_in = slot_free ? fin_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== src/decimal_text_to_fixed_point.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses signed decimal ASCII text, one character per beat, into a signed
// fixed-point value with validity, integer, sign and saturation flags.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type (char_code, end_of_text)
//   rsp_      out        rsp_valid/rsp_stall  rsp_type (number_out and flags)
//
// one character beat per cycle, sustained unless a last character waits on
// a full holding register; the parse state recurrence (multiply-by-ten add,
// fraction table add) is combinational; a result beat passes the input
// register, parse and holding register, then result register
// reset clears all valid bits and the parse state
// rsp_stall backs up through the holding and input registers to req_stall
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point
   import dttfp_pkg::*;
#(
   parameter int WHOLE_BITS      = DEF_WHOLE_BITS,
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    item_take;
   logic    fin_valid, fin_take;
   fin_type fin;

   assign req_stall   = in_valid_ff && !item_take;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
   end

   dttfp_parse #(
      .WHOLE_BITS      (WHOLE_BITS),
      .FRAC_BITS       (FRAC_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_ff),
      .item_take  (item_take),
      .fin_take   (fin_take),
      .fin_valid  (fin_valid),
      .fin        (fin)
   );

   dttfp_format u_format (
      .clock       (clock),
      .reset       (reset),
      .fin_valid   (fin_valid),
      .fin         (fin),
      .fin_take    (fin_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   // invalid text carries an all-zero result
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.text_valid |->
         rsp_payload.number_out == '0 && !rsp_payload.is_whole_number &&
         !rsp_payload.is_above_zero && !rsp_payload.whole_saturated)
      else $error("invalid text gave a nonzero result");

   a_positive_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_above_zero |-> !rsp_payload.number_out[NUM_W-1])
      else $error("positive flag on a negative value");

   a_whole_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_whole_number |->
         rsp_payload.number_out[FRAC_BITS-1:0] == '0)
      else $error("integer flag with fraction bits set");

   // a stall toward the sender only comes with a held character beat
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_ff.end_of_text && fin_valid)
      else $error("stall without a blocked last character");
`endif

endmodule
`default_nettype wire

// ===== sim/decimal_text_to_fixed_point_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_tb
// Feeds ASCII number texts one character per beat: a short table of corner
// texts, then random well-formed, broken and noise texts under four idling
// phases. Results are checked per field against the known row or local parser.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_tb
   import dttfp_pkg::*;
();

   localparam int CAP_BITS = (DEF_WHOLE_BITS > MAG_W - DEF_FRAC_BITS) ?
                             MAG_W - DEF_FRAC_BITS : DEF_WHOLE_BITS;
   localparam logic [63:0] WHOLE_CAP = (64'd1 << CAP_BITS) - 64'd1;
   localparam int FRAC_LIMIT = (DEF_MAX_FRAC_DIGITS > MAX_FRAC_LIMIT) ?
                               MAX_FRAC_LIMIT : DEF_MAX_FRAC_DIGITS;
   localparam int PHASE_CHARS = 425;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int SEND_IDLE_PCT [4] = '{0, 83, 0, 36};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 83, 36};
   localparam rsp_type NO_NUMBER = '0;

   typedef struct {
      logic [95:0] chars;
      int          len;
      bit          known;
      rsp_type     rsp;
   } text_row_type;

   // text is right-aligned in chars; known rows carry their result
   text_row_type dir_rows [12] = '{
      '{"0",          1,  1'b1, '{48'h0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{96'h00,       1,  1'b1, NO_NUMBER},
      '{96'hff,       1,  1'b1, NO_NUMBER},
      '{"-0",         2,  1'b1, '{48'h0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{"1-",         2,  1'b1, NO_NUMBER},
      '{"1.,",        3,  1'b1, NO_NUMBER},
      '{"-",          1,  1'b1, NO_NUMBER},
      '{"5.",         2,  1'b0, NO_NUMBER},
      '{",5",         2,  1'b0, NO_NUMBER},
      '{"-1",         2,  1'b1, '{48'hffff_ffff_0000, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{"9999999999", 10, 1'b1, '{48'h7fff_ffff_0000, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{"0.123456",   8,  1'b0, NO_NUMBER}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // parser state
   bit          at_start;
   bit          neg_sign;
   bit          text_bad;
   int unsigned sep_count;
   bit          saw_digit;
   logic [63:0] whole_acc;
   logic [63:0] frac_acc;
   int unsigned frac_digits;
   bit          whole_clamped;

   rsp_type     number_q [$];
   logic [7:0]  text_q [$];
   int          fail_count = 0;
   int          send_idle = 0;
   int          recv_stall = 0;
   int unsigned cycle_count = 0;

   decimal_text_to_fixed_point u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void clear_parse();
      at_start = 1'b1;
      neg_sign = 1'b0;
      text_bad = 1'b0;
      sep_count = 0;
      saw_digit = 1'b0;
      whole_acc = '0;
      frac_acc = '0;
      frac_digits = 0;
      whole_clamped = 1'b0;
   endfunction

   // returns 1 when the character closes a text; result holds the number
   function automatic bit parse_char(input req_type beat, output rsp_type result);
      logic [7:0]  c;
      logic [63:0] grown;
      logic [63:0] scale;
      logic [63:0] frac;
      logic [63:0] mag;
      logic [63:0] signed_mag;
      c = beat.char_code;
      result = NO_NUMBER;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         saw_digit = 1'b1;
         if (sep_count == 0) begin
            grown = whole_acc * 64'd10 + 64'(c - CHAR_ZERO);
            if (grown > WHOLE_CAP) begin
               grown = WHOLE_CAP;
               whole_clamped = 1'b1;
            end
            whole_acc = grown;
         end else if (frac_digits < FRAC_LIMIT) begin
            frac_acc = frac_acc * 64'd10 + 64'(c - CHAR_ZERO);
            frac_digits++;
         end
      end else if (c == CHAR_DOT || c == CHAR_COMMA) begin
         if (sep_count >= 1) text_bad = 1'b1;
         if (sep_count < 2) sep_count++;
      end else if (c == CHAR_MINUS) begin
         if (at_start) neg_sign = 1'b1;
         else text_bad = 1'b1;
      end else begin
         text_bad = 1'b1;
      end
      at_start = 1'b0;
      if (!beat.end_of_text) return 1'b0;

      scale = 64'd1;
      for (int i = 0; i < frac_digits; i++) scale = scale * 64'd10;
      frac = (frac_acc << DEF_FRAC_BITS) / scale;
      mag = (whole_acc << DEF_FRAC_BITS) | frac;
      signed_mag = neg_sign ? 64'd0 - mag : mag;
      if (!text_bad && saw_digit) begin
         result.number_out = signed_mag[NUM_W-1:0];
         result.text_valid = 1'b1;
         result.is_whole_number = (frac == 0);
         result.is_above_zero = (mag != 0) && !neg_sign;
         result.whole_saturated = whole_clamped;
      end
      clear_parse();
      return 1'b1;
   endfunction

   task automatic send_text(input bit known, input rsp_type known_rsp);
      req_type beat;
      rsp_type predicted;
      for (int i = 0; i < text_q.size(); i++) begin
         beat.char_code = text_q[i];
         beat.end_of_text = (i == text_q.size() - 1);
         while ($urandom_range(1, 100) <= send_idle) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_payload <= beat;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         if (parse_char(beat, predicted)) number_q.push_back(known ? known_rsp : predicted);
      end
   endtask

   function automatic void add_digits(input int count);
      repeat (count) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void build_number();
      int whole_n;
      int frac_n;
      frac_n = 0;
      text_q.delete();
      if ($urandom_range(0, 99) < 30) text_q.push_back(CHAR_MINUS);
      // a few long whole parts so the clamp gets hit
      whole_n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 4);
      add_digits(whole_n);
      if ($urandom_range(0, 99) < 60) begin
         text_q.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA);
         frac_n = $urandom_range(0, 8);
         add_digits(frac_n);
      end
      if (whole_n == 0 && frac_n == 0) add_digits(1);
   endfunction

   function automatic void break_text();
      logic [7:0] marks [3] = '{CHAR_MINUS, CHAR_DOT, CHAR_COMMA};
      case ($urandom_range(0, 3))
         0: begin
            text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
         end
         1: begin
            text_q.insert($urandom_range(0, text_q.size()),
                          $urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA);
         end
         2: begin
            text_q.insert($urandom_range(1, text_q.size()), CHAR_MINUS);
         end
         default: begin
            // signs and separators only, no digit at all
            text_q.delete();
            repeat ($urandom_range(1, 3)) text_q.push_back(marks[$urandom_range(0, 2)]);
         end
      endcase
   endfunction

   function automatic void flag_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fail_count++;
   endfunction

   function automatic void check_number(input rsp_type got);
      rsp_type want;
      if (number_q.size() == 0) begin
         $display("%0t: result beat with nothing expected, got %h", $time, got);
         fail_count++;
         return;
      end
      want = number_q.pop_front();
      if (got.number_out !== want.number_out)
         flag_field("number_out", want.number_out, got.number_out);
      if (got.text_valid !== want.text_valid)
         flag_field("text_valid", 48'(want.text_valid), 48'(got.text_valid));
      if (got.is_whole_number !== want.is_whole_number)
         flag_field("is_whole_number", 48'(want.is_whole_number), 48'(got.is_whole_number));
      if (got.is_above_zero !== want.is_above_zero)
         flag_field("is_above_zero", 48'(want.is_above_zero), 48'(got.is_above_zero));
      if (got.whole_saturated !== want.whole_saturated)
         flag_field("whole_saturated", 48'(want.whole_saturated), 48'(got.whole_saturated));
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) check_number(rsp_payload);
         rsp_stall <= ($urandom_range(1, 100) <= recv_stall);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d results still expected", $time, number_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int sent;
      int kind;
      clear_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         text_q.delete();
         for (int i = dir_rows[r].len - 1; i >= 0; i--)
            text_q.push_back(dir_rows[r].chars[8*i +: 8]);
         send_text(dir_rows[r].known, dir_rows[r].rsp);
      end

      for (int m = 0; m < 4; m++) begin
         send_idle = SEND_IDLE_PCT[m];
         recv_stall = RECV_STALL_PCT[m];
         sent = 0;
         while (sent < PHASE_CHARS) begin
            kind = $urandom_range(0, 99);
            if (kind < 90) begin
               build_number();
               if (kind >= 70) break_text();
            end else begin
               text_q.delete();
               repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
            end
            send_text(1'b0, NO_NUMBER);
            sent += text_q.size();
         end
      end
      req_valid <= 1'b0;

      while (number_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
